// ===== hw/rtl/dsd_pkg.sv =====
// Shared types and constants for the depth deviation and score unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package dsd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NORM_KMER  = 2'd0;
    localparam logic [1:0] CFG_SEQ_LENGTH = 2'd1;
    localparam logic [1:0] CFG_BASES_COV  = 2'd2;

    // Datapath operations.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_SAMPLE   = 4'd1;
    localparam logic [3:0] OP_START    = 4'd2;
    localparam logic [3:0] OP_LD_NS2   = 4'd3;
    localparam logic [3:0] OP_MUL_STEP = 4'd4;
    localparam logic [3:0] OP_LD_SS    = 4'd5;
    localparam logic [3:0] OP_LD_DIVV  = 4'd6;
    localparam logic [3:0] OP_DIV_STEP = 4'd7;
    localparam logic [3:0] OP_LD_SQRT  = 4'd8;
    localparam logic [3:0] OP_SQ_STEP  = 4'd9;
    localparam logic [3:0] OP_LD_NUM   = 4'd10;
    localparam logic [3:0] OP_LD_DIVS  = 4'd11;
    localparam logic [3:0] OP_OUT      = 4'd12;

    // Step counts of the iterative units, less one.
    localparam logic [6:0] MUL_LAST  = 7'd39;
    localparam logic [6:0] DIV_LAST  = 7'd127;
    localparam logic [6:0] SQRT_LAST = 7'd63;

    // Working widths.
    localparam int CNT_W  = 17;
    localparam int SUM_W  = 40;
    localparam int SQS_W  = 64;
    localparam int PROD_W = 81;
    localparam int QUO_W  = 128;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic few_samples;
    } status_t;

endpackage

// ===== hw/rtl/dsd_datapath.sv =====
// Datapath: sample accumulators, configuration registers, a shift-add
// multiplier, a restoring divider, a digit-by-digit square root and the
// result register. Depends on dsd_pkg.
`timescale 1ns / 1ps

module dsd_datapath #(
    parameter int MAX_SAMPLES  = 65536,
    parameter int DEPTH_BITS   = 24,
    parameter int SD_FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dsd_pkg::cmd_t       cmd,
    output dsd_pkg::status_t    status,
    input  logic [23:0]         depth,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output logic [31:0]         depth_sd,
    output logic                sd_valid,
    output logic [31:0]         score,
    output logic                score_saturated,
    output logic                samples_dropped
);

    localparam logic [23:0] DEPTH_MASK = 24'((25'd1 << DEPTH_BITS) - 25'd1);
    localparam int          VAR_SHIFT  = 2 * SD_FRAC_BITS;
    localparam logic [dsd_pkg::CNT_W-1:0] MAX_CNT = dsd_pkg::CNT_W'(MAX_SAMPLES);

    logic [dsd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [dsd_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [dsd_pkg::SQS_W-1:0]  sqs_reg, sqs_next;
    logic                       ovf_reg, ovf_next;
    logic [23:0]                nk_reg;
    logic [31:0]                len_reg, cov_reg;

    logic [dsd_pkg::PROD_W-1:0] acc_reg, acc_next, mcand_reg, mcand_next, t_reg, t_next;
    logic [39:0]                mplier_reg, mplier_next;
    logic [dsd_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [63:0]                dvs_reg, dvs_next, rem_reg, rem_next;
    logic [63:0]                root_reg, root_next;
    logic [65:0]                srem_reg, srem_next;
    logic [31:0]                sd_reg, sd_next;
    logic                       valid_reg, valid_next;

    logic [31:0] sdo_reg, sdo_next, score_reg, score_next;
    logic        sdv_reg, sdv_next, sat_reg, sat_next, drop_reg, drop_next;

    logic [23:0]                dep;
    logic [47:0]                dep_sq;
    logic [33:0]                cnt_prod;
    logic [64:0]                div_sh;
    logic [67:0]                sq_sh, sq_trial;
    logic [dsd_pkg::CNT_W-1:0]  n_m1;
    logic                       cov_ok, sat_q;
    logic [31:0]                d_eff, s_eff;

    assign dep      = depth & DEPTH_MASK;
    assign dep_sq   = 48'(dep) * 48'(dep);
    assign div_sh   = {rem_reg, quo_reg[dsd_pkg::QUO_W-1]};
    assign sq_sh    = {srem_reg, quo_reg[dsd_pkg::QUO_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign n_m1     = cnt_reg - dsd_pkg::CNT_W'(1);
    assign cnt_prod = 34'(cnt_reg) * 34'(n_m1);
    assign cov_ok   = (len_reg != 32'd0) && (cov_reg != 32'd0);
    assign d_eff    = cov_ok ? len_reg : 32'd10;
    assign s_eff    = valid_reg ? sd_reg : 32'd1;
    assign sat_q    = (valid_reg && (sd_reg == 32'd0)) || (quo_reg[dsd_pkg::QUO_W-1:32] != '0);

    assign status.few_samples = cnt_reg < dsd_pkg::CNT_W'(2);

    always_comb
    begin
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        sqs_next    = sqs_reg;
        ovf_next    = ovf_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        t_next      = t_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        srem_next   = srem_reg;
        sd_next     = sd_reg;
        valid_next  = valid_reg;
        sdo_next    = sdo_reg;
        sdv_next    = sdv_reg;
        score_next  = score_reg;
        sat_next    = sat_reg;
        drop_next   = drop_reg;
        case (cmd.op)
            dsd_pkg::OP_SAMPLE:
            begin
                if (cnt_reg < MAX_CNT)
                begin
                    cnt_next = cnt_reg + dsd_pkg::CNT_W'(1);
                    sum_next = sum_reg + dsd_pkg::SUM_W'(dep);
                    sqs_next = sqs_reg + dsd_pkg::SQS_W'(dep_sq);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            dsd_pkg::OP_START:
            begin
                valid_next = !status.few_samples;
            end
            dsd_pkg::OP_LD_NS2:
            begin
                acc_next    = '0;
                mcand_next  = dsd_pkg::PROD_W'(sqs_reg);
                mplier_next = 40'(cnt_reg);
            end
            dsd_pkg::OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[dsd_pkg::PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[39:1]};
            end
            dsd_pkg::OP_LD_SS:
            begin
                t_next      = acc_reg;
                acc_next    = '0;
                mcand_next  = dsd_pkg::PROD_W'(sum_reg);
                mplier_next = sum_reg;
            end
            dsd_pkg::OP_LD_DIVV:
            begin
                quo_next = dsd_pkg::QUO_W'(t_reg - acc_reg) << VAR_SHIFT;
                dvs_next = 64'(cnt_prod);
                rem_next = '0;
            end
            dsd_pkg::OP_DIV_STEP:
            begin
                if (div_sh >= {1'b0, dvs_reg})
                begin
                    rem_next = 64'(div_sh - {1'b0, dvs_reg});
                    quo_next = {quo_reg[dsd_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh[63:0];
                    quo_next = {quo_reg[dsd_pkg::QUO_W-2:0], 1'b0};
                end
            end
            dsd_pkg::OP_LD_SQRT:
            begin
                root_next = '0;
                srem_next = '0;
            end
            dsd_pkg::OP_SQ_STEP:
            begin
                if (sq_sh >= sq_trial)
                begin
                    srem_next = 66'(sq_sh - sq_trial);
                    root_next = {root_reg[62:0], 1'b1};
                end
                else
                begin
                    srem_next = sq_sh[65:0];
                    root_next = {root_reg[62:0], 1'b0};
                end
                quo_next = {quo_reg[dsd_pkg::QUO_W-3:0], 2'b00};
            end
            dsd_pkg::OP_LD_NUM:
            begin
                if (!valid_reg)
                begin
                    sd_next = '0;
                end
                else if (root_reg[63:32] != '0)
                begin
                    sd_next = '1;
                end
                else
                begin
                    sd_next = root_reg[31:0];
                end
                acc_next    = '0;
                mcand_next  = cov_ok ? (dsd_pkg::PROD_W'(cov_reg) << 3)
                                       + (dsd_pkg::PROD_W'(cov_reg) << 1)
                                     : dsd_pkg::PROD_W'(1);
                mplier_next = 40'(nk_reg);
            end
            dsd_pkg::OP_LD_DIVS:
            begin
                // A zero deviation gives a zero divisor; the quotient then saturates anyway.
                quo_next = valid_reg ? (dsd_pkg::QUO_W'(acc_reg) << SD_FRAC_BITS)
                                     : dsd_pkg::QUO_W'(acc_reg);
                dvs_next = d_eff * s_eff;
                rem_next = '0;
            end
            dsd_pkg::OP_OUT:
            begin
                sdo_next   = sd_reg;
                sdv_next   = valid_reg;
                sat_next   = sat_q;
                score_next = sat_q ? '1 : quo_reg[31:0];
                drop_next  = ovf_reg;
                cnt_next   = '0;
                sum_next   = '0;
                sqs_next   = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sqs_reg <= '0;
            ovf_reg <= 1'b0;
            nk_reg  <= '0;
            len_reg <= '0;
            cov_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            sqs_reg <= sqs_next;
            ovf_reg <= ovf_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dsd_pkg::CFG_NORM_KMER:  nk_reg  <= cfg_wdata[23:0];
                    dsd_pkg::CFG_SEQ_LENGTH: len_reg <= cfg_wdata;
                    dsd_pkg::CFG_BASES_COV:  cov_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        t_reg      <= t_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        sd_reg     <= sd_next;
        valid_reg  <= valid_next;
        sdo_reg    <= sdo_next;
        sdv_reg    <= sdv_next;
        score_reg  <= score_next;
        sat_reg    <= sat_next;
        drop_reg   <= drop_next;
    end

    assign depth_sd        = sdo_reg;
    assign sd_valid        = sdv_reg;
    assign score           = score_reg;
    assign score_saturated = sat_reg;
    assign samples_dropped = drop_reg;

endmodule

// ===== hw/rtl/dsd_controller.sv =====
// Controller: input and output handshakes and the sequencer that steps the
// datapath through the finish computation. Depends on dsd_pkg.
`timescale 1ns / 1ps

module dsd_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    output logic                out_valid,
    input  logic                out_stall,
    output dsd_pkg::cmd_t       cmd,
    input  dsd_pkg::status_t    status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_LDA   = 4'd2;
    localparam logic [3:0] S_MA    = 4'd3;
    localparam logic [3:0] S_LDB   = 4'd4;
    localparam logic [3:0] S_MB    = 4'd5;
    localparam logic [3:0] S_LDD   = 4'd6;
    localparam logic [3:0] S_DA    = 4'd7;
    localparam logic [3:0] S_LDQ   = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_LDN   = 4'd10;
    localparam logic [3:0] S_MC    = 4'd11;
    localparam logic [3:0] S_LDS   = 4'd12;
    localparam logic [3:0] S_DB    = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [6:0] step_reg, step_next;
    logic       ovalid_reg, ovalid_next;
    logic       in_xfer, out_free;

    assign in_stall  = state_reg != S_IDLE;
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !ovalid_reg || !out_stall;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd.op      = dsd_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        cmd.op = dsd_pkg::OP_SAMPLE;
                    end
                end
            end
            S_START:
            begin
                cmd.op     = dsd_pkg::OP_START;
                state_next = status.few_samples ? S_LDN : S_LDA;
            end
            S_LDA:
            begin
                cmd.op     = dsd_pkg::OP_LD_NS2;
                state_next = S_MA;
            end
            S_LDB:
            begin
                cmd.op     = dsd_pkg::OP_LD_SS;
                state_next = S_MB;
            end
            S_LDD:
            begin
                cmd.op     = dsd_pkg::OP_LD_DIVV;
                state_next = S_DA;
            end
            S_LDQ:
            begin
                cmd.op     = dsd_pkg::OP_LD_SQRT;
                state_next = S_SQ;
            end
            S_LDN:
            begin
                cmd.op     = dsd_pkg::OP_LD_NUM;
                state_next = S_MC;
            end
            S_LDS:
            begin
                cmd.op     = dsd_pkg::OP_LD_DIVS;
                state_next = S_DB;
            end
            S_MA, S_MB, S_MC:
            begin
                cmd.op    = dsd_pkg::OP_MUL_STEP;
                step_next = step_reg + 7'd1;
                if (step_reg == dsd_pkg::MUL_LAST)
                begin
                    step_next  = '0;
                    state_next = (state_reg == S_MA) ? S_LDB :
                                 (state_reg == S_MB) ? S_LDD : S_LDS;
                end
            end
            S_DA, S_DB:
            begin
                cmd.op    = dsd_pkg::OP_DIV_STEP;
                step_next = step_reg + 7'd1;
                if (step_reg == dsd_pkg::DIV_LAST)
                begin
                    step_next  = '0;
                    state_next = (state_reg == S_DA) ? S_LDQ : S_DONE;
                end
            end
            S_SQ:
            begin
                cmd.op    = dsd_pkg::OP_SQ_STEP;
                step_next = step_reg + 7'd1;
                if (step_reg == dsd_pkg::SQRT_LAST)
                begin
                    step_next  = '0;
                    state_next = S_LDN;
                end
            end
            S_DONE:
            begin
                // The result register is loaded once the previous result has gone.
                if (out_free)
                begin
                    cmd.op      = dsd_pkg::OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== hw/rtl/depth_stddev_and_score_unit.sv =====
// Channel  | Handshake           | Payload
// input    | in_valid / in_stall | action, depth
// output   | out_valid/out_stall | depth_sd, sd_valid, score, score_saturated, samples_dropped
// config   | cfg_we              | cfg_index, cfg_wdata
//
// Depth samples may arrive back to back while the unit is idle. A finish item
// runs the bit-serial multiplier (40 steps, three passes), the restoring
// divider (128 steps, two passes) and the square root (64 steps); fewer than
// two samples skips to the score pass. The input stalls during that work; a
// result waiting on out_stall does not block sample transfers. Reset clears the
// accumulators, the configuration registers and the controller state.
// Top level of the depth deviation and score unit; uses dsd_pkg, dsd_controller
// and dsd_datapath.
`timescale 1ns / 1ps

module depth_stddev_and_score_unit #(
    parameter int MAX_SAMPLES  = 65536,
    parameter int DEPTH_BITS   = 24,
    parameter int SD_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [23:0] depth,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] depth_sd,
    output logic        sd_valid,
    output logic [31:0] score,
    output logic        score_saturated,
    output logic        samples_dropped,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    dsd_pkg::cmd_t    cmd;
    dsd_pkg::status_t status;

    dsd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    dsd_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .DEPTH_BITS   (DEPTH_BITS),
        .SD_FRAC_BITS (SD_FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .depth           (depth),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .depth_sd        (depth_sd),
        .sd_valid        (sd_valid),
        .score           (score),
        .score_saturated (score_saturated),
        .samples_dropped (samples_dropped)
    );

    // A new result only follows a finish computation, during which the input stalls.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a finish computation");

    a_invalid_sd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sd_valid |-> depth_sd == 32'd0)
        else $error("deviation not zero with too few samples");

    a_zero_sd_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sd_valid && depth_sd == 32'd0 |-> score_saturated && score == '1)
        else $error("zero deviation did not saturate the score");

endmodule
